// File: rtl/sfd_pkg.sv
// shared types, constants and the crc byte update for the sync frame decoder
// no dependencies
package sfd_pkg;

  localparam int SFD_QUEUE_DEPTH = 2;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD = 2'd2;

  localparam logic [7:0]  SYNC_FIRST_RST  = 8'hAA;
  localparam logic [7:0]  SYNC_SECOND_RST = 8'h55;
  localparam logic [15:0] MAX_PAYLOAD_RST = 16'd256;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_TOP  = 16'h8000;

  typedef enum logic [2:0] {
    PH_SYNC1,
    PH_SYNC2,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_PAYLOAD,
    PH_CRC_HI,
    PH_CRC_LO
  } phase_t;

  // what the back end has to do with a byte
  typedef enum logic [2:0] {
    K_NONE,
    K_START,
    K_PAYLOAD,
    K_CRC_HI,
    K_CRC_LO
  } kind_t;

  typedef struct packed {
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    logic [15:0] max_payload;
  } cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic        reject;
    logic [7:0]  data;
    logic [15:0] length;
  } item_t;

  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_data;
    logic        frame_done;
    logic        frame_ok;
    logic        length_reject;
    logic [15:0] frame_length;
  } res_t;

  // crc-16/ccitt-false, one byte msb first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: rtl/sfd_fifo.sv
// small register queue, first in first out, show-ahead read
// depends on nothing but its parameters
module sfd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push_ok, pop_ok;

  assign full    = (count_r == CNT_FULL);
  assign empty   = (count_r == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign rdata   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push_ok && !pop_ok) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop_ok && !push_ok) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

endmodule

// File: rtl/sfd_front.sv
// frame parser: tracks sync, length and payload count, tags each byte
// depends on sfd_pkg
module sfd_front import sfd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       req,
  input  logic       stall,
  input  logic [7:0] rx_byte,
  output logic       item_push,
  output item_t      item
);

  phase_t      phase_r, phase_nxt;
  logic [15:0] length_r, length_nxt;
  logic [15:0] count_r, count_nxt;
  logic [15:0] count_inc;
  logic        take;

  assign take      = req && !stall;
  assign item_push = req;
  assign count_inc = count_r + 16'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SYNC1;
      length_r <= '0;
      count_r  <= '0;
    end else if (take) begin
      phase_r  <= phase_nxt;
      length_r <= length_nxt;
      count_r  <= count_nxt;
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    length_nxt  = length_r;
    count_nxt   = count_r;
    item.kind   = K_NONE;
    item.reject = 1'b0;
    item.data   = rx_byte;
    case (phase_r)
      PH_SYNC2: begin
        phase_nxt = (rx_byte == cfg.sync_second) ? PH_LEN_HI : PH_SYNC1;
      end
      PH_LEN_HI: begin
        length_nxt = {rx_byte, 8'h00};
        phase_nxt  = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        length_nxt = {length_r[15:8], rx_byte};
        count_nxt  = '0;
        item.kind  = K_START;
        if (length_nxt > cfg.max_payload) begin
          item.reject = 1'b1;
          phase_nxt   = PH_SYNC1;
        end else if (length_nxt == 16'd0) begin
          phase_nxt = PH_CRC_HI;
        end else begin
          phase_nxt = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        item.kind = K_PAYLOAD;
        count_nxt = count_inc;
        if (count_inc >= length_r) begin
          phase_nxt = PH_CRC_HI;
        end
      end
      PH_CRC_HI: begin
        item.kind = K_CRC_HI;
        phase_nxt = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        item.kind = K_CRC_LO;
        phase_nxt = PH_SYNC1;
      end
      default: begin
        // hunting, also the unused phase code
        phase_nxt = (rx_byte == cfg.sync_first) ? PH_SYNC2 : PH_SYNC1;
      end
    endcase
    item.length = length_nxt;
  end

endmodule

// File: rtl/sfd_back.sv
// crc engine: running crc over payload bytes and the final check
// depends on sfd_pkg
module sfd_back import sfd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  item_valid,
  input  item_t item,
  output logic  item_pop,
  input  logic  res_full,
  output logic  res_push,
  output res_t  res
);

  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  crc_hi_r, crc_hi_nxt;
  logic        fire;

  assign fire     = item_valid && !res_full;
  assign item_pop = fire;
  assign res_push = fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r    <= CRC_INIT;
      crc_hi_r <= '0;
    end else if (fire) begin
      crc_r    <= crc_nxt;
      crc_hi_r <= crc_hi_nxt;
    end
  end

  always_comb begin
    crc_nxt           = crc_r;
    crc_hi_nxt        = crc_hi_r;
    res.payload_valid = 1'b0;
    res.payload_data  = 8'h00;
    res.frame_done    = 1'b0;
    res.frame_ok      = 1'b0;
    res.length_reject = item.reject;
    res.frame_length  = item.length;
    case (item.kind)
      K_START: begin
        crc_nxt = CRC_INIT;
      end
      K_PAYLOAD: begin
        crc_nxt           = crc16_byte(crc_r, item.data);
        res.payload_valid = 1'b1;
        res.payload_data  = item.data;
      end
      K_CRC_HI: begin
        crc_hi_nxt = item.data;
      end
      K_CRC_LO: begin
        res.frame_done = 1'b1;
        res.frame_ok   = ({crc_hi_r, item.data} == crc_r);
      end
      default: begin
        crc_nxt = crc_r;
      end
    endcase
  end

endmodule

// File: rtl/sync_frame_decoder_crc16.sv
// Sync/length/payload/CRC frame decoder. Takes one received byte per cycle
// while in_full is low and gives one result per byte; sustained rate is one
// byte per clock while out_pop drains the result queue, set by the parser
// state machine and the eight-bit unrolled CRC update. An accepted byte is
// classified by the parser into the internal queue, then taken by the CRC
// engine into the result queue, whose head drives the out_ ports. Both
// queues are QUEUE_DEPTH deep, so either side may stall without losing a byte.
// Configuration (sync bytes, max payload length) is written through cfg_.
// depends on sfd_pkg, sfd_fifo, sfd_front, sfd_back
module sync_frame_decoder_crc16 import sfd_pkg::*; #(
  parameter int QUEUE_DEPTH = SFD_QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [7:0]            in_rx_byte,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic                  out_payload_valid,
  output logic [7:0]            out_payload_data,
  output logic                  out_frame_done,
  output logic                  out_frame_ok,
  output logic                  out_length_reject,
  output logic [15:0]           out_frame_length
);

  localparam int ITEM_W = $bits(item_t);
  localparam int RES_W  = $bits(res_t);

  cfg_t  cfg_r, cfg_nxt;
  logic  item_push, item_pop, mid_full, mid_empty;
  item_t item_in, item_out;
  logic  res_push, res_full;
  res_t  res_in, res_out;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_SYNC_FIRST:  cfg_nxt.sync_first  = cfg_wdata[7:0];
        REG_SYNC_SECOND: cfg_nxt.sync_second = cfg_wdata[7:0];
        REG_MAX_PAYLOAD: cfg_nxt.max_payload = cfg_wdata[15:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_first  <= SYNC_FIRST_RST;
      cfg_r.sync_second <= SYNC_SECOND_RST;
      cfg_r.max_payload <= MAX_PAYLOAD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_full = mid_full;

  sfd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .req       (in_push),
    .stall     (mid_full),
    .rx_byte   (in_rx_byte),
    .item_push (item_push),
    .item      (item_in)
  );

  sfd_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (item_push),
    .wdata (item_in),
    .full  (mid_full),
    .pop   (item_pop),
    .rdata (item_out),
    .empty (mid_empty)
  );

  sfd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (!mid_empty),
    .item       (item_out),
    .item_pop   (item_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (res_in)
  );

  sfd_fifo #(
    .WIDTH (RES_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_out),
    .empty (out_empty)
  );

  assign out_payload_valid = res_out.payload_valid;
  assign out_payload_data  = res_out.payload_data;
  assign out_frame_done    = res_out.frame_done;
  assign out_frame_ok      = res_out.frame_ok;
  assign out_length_reject = res_out.length_reject;
  assign out_frame_length  = res_out.frame_length;

  // an accepted byte always lands in the internal queue
  a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full) |=> !mid_empty)
    else $error("accepted byte missing from internal queue");

  // the crc engine never pushes into a full result queue
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result queue overrun");

  // frame ok only comes with frame done
  a_ok_done: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_frame_ok) |-> out_frame_done)
    else $error("frame_ok without frame_done");

  // a byte is at most one of payload, crc end, length reject
  a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> ($countones({out_payload_valid, out_frame_done, out_length_reject}) <= 1))
    else $error("result flags overlap");

endmodule
